[design/glyph_ink_max_blit_top_assert.svh]
// assertion macros shared by the glyph blit checker
`ifndef GLYPH_INK_MAX_BLIT_TOP_ASSERT_SVH
`define GLYPH_INK_MAX_BLIT_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define GIMB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define GIMB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/gimb_pkg.sv]
// types, register codes and reset values for the glyph ink blit
package gimb_pkg;

    // store size in bytes, power of two, at least 256
    localparam int STORE_BYTES_DEF = 65536;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_FORMAT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SURFACE_WIDTH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SURFACE_HEIGHT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_PITCH     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SURFACE_BASE   = 3'd4;

    // pixel formats, codes above FMT_ARGB behave as FMT_ARGB
    localparam logic [2:0] FMT_NIB_LO = 3'd0;
    localparam logic [2:0] FMT_NIB_HI = 3'd1;
    localparam logic [2:0] FMT_BYTE   = 3'd2;
    localparam logic [2:0] FMT_RGB    = 3'd3;
    localparam logic [2:0] FMT_ARGB   = 3'd4;

    localparam logic [2:0]  RST_PIXEL_FORMAT   = FMT_ARGB;
    localparam logic [15:0] RST_SURFACE_WIDTH  = 16'd256;
    localparam logic [15:0] RST_SURFACE_HEIGHT = 16'd256;
    localparam logic [15:0] RST_LINE_PITCH     = 16'd1024;
    localparam logic [15:0] RST_SURFACE_BASE   = 16'd0;

    typedef struct packed {
        logic signed [31:0] pen_x;
        logic signed [31:0] pen_y;
        logic signed [7:0]  glyph_left;
        logic signed [7:0]  glyph_top;
        logic        [7:0]  pixel_row;
        logic        [7:0]  pixel_column;
        logic        [7:0]  ink;
    } t_glyph_in;

    typedef struct packed {
        logic        written;
        logic [15:0] byte_address;
        logic [31:0] write_data;
        logic [2:0]  byte_count;
    } t_blit_out;

endpackage

[design/gimb_ram.sv]
// generic single-port-write, registered-read ram
module gimb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the contents before a same-edge write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/glyph_ink_max_blit_top.sv]
// glyph pixel blit into a local surface store with max-ink merge
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one glyph pixel per
// transfer; output channel (o_out_valid / i_out_ready / o_out_data) returns one
// result per pixel, in order. Configuration is written through i_cfg_we,
// i_cfg_index and i_cfg_data while no pixel is in flight.
//
// Throughput is one pixel per cycle while the receiver keeps up and no clearing
// pass runs. Between an input transfer and its result on the output, the
// transfer edge registers the pixel position, then come clip with line pitch
// multiply, address add, store read, merge with store write-back.
// The store sits in four byte-lane rams, so all bytes of a 3- or 4-byte pixel
// are written together; a read that hits the byte being written on the same
// edge is forwarded.
//
// Reset returns the configuration to its defaults and starts a clearing pass
// that zeroes every row of the store, during which o_in_ready stays low. When
// the receiver stalls, the output register holds its result and each stage
// holds as soon as the stage after it is full; up to five pixels are then
// held inside before o_in_ready drops.
module glyph_ink_max_blit_top #(
    parameter int STORE_BYTES = gimb_pkg::STORE_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gimb_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [gimb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  gimb_pkg::t_glyph_in              i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output gimb_pkg::t_blit_out              o_out_data
);

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int ROW_W  = ADDR_W - 2;
    localparam int ROWS   = STORE_BYTES / 4;

    // configuration
    logic [2:0]  r_pixel_format;
    logic [15:0] r_surface_width;
    logic [15:0] r_surface_height;
    logic [15:0] r_line_pitch;
    logic [15:0] r_surface_base;

    // clearing pass
    logic             r_clr_busy;
    logic [ROW_W-1:0] r_clr_row;

    // pipeline registers
    logic              r1_valid, r2_valid, r3_valid, r4_valid, r_out_valid;
    logic [27:0]       r1_x, r1_y;
    logic [7:0]        r1_ink, r2_ink, r3_ink, r4_ink;
    logic              r2_pass, r3_pass, r4_pass;
    logic [31:0]       r2_prod;
    logic [17:0]       r2_off;
    logic              r2_xodd;
    logic [ADDR_W-1:0] r3_at, r4_at;
    logic              r3_high, r4_high;
    logic [1:0]        r4_bank;
    logic              r4_fwd_hit;
    logic [7:0]        r4_fwd_byte;
    gimb_pkg::t_blit_out r_out_data;

    // next values
    logic [27:0]       n1_x, n1_y;
    logic              n2_pass;
    logic [31:0]       n2_prod;
    logic [17:0]       n2_off;
    logic [ADDR_W-1:0] n3_at;
    logic              n3_high;

    // flow control
    logic out_free, s4_move, s4_free, s3_free, s2_free, s1_free, in_xfer;

    // store access
    logic [ADDR_W-1:0] rd_byte;
    logic [1:0]        rd_bank;
    logic [ROW_W-1:0]  rd_row;
    logic [ROW_W-1:0]  r4_row;
    logic              fwd_hit;
    logic [7:0]        bank_rdata [4];
    logic              s4_we      [4];
    logic [ROW_W-1:0]  s4_wrow    [4];
    logic [7:0]        s4_wbyte   [4];
    logic              bank_we    [4];
    logic [ROW_W-1:0]  bank_wrow  [4];
    logic [7:0]        bank_wbyte [4];

    // merge
    logic [7:0]          old_byte, max_byte, nib_byte;
    logic [3:0]          old_nib, new_nib;
    gimb_pkg::t_blit_out res;

    assign out_free = !r_out_valid || i_out_ready;
    assign s4_move  = r4_valid && out_free;
    assign s4_free  = !r4_valid || s4_move;
    assign s3_free  = !r3_valid || s4_free;
    assign s2_free  = !r2_valid || s3_free;
    assign s1_free  = !r1_valid || s2_free;

    assign o_in_ready  = s1_free && !r_clr_busy;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // stage 1: floor pen to pixels and add glyph offsets
    assign n1_x = {{2{i_in_data.pen_x[31]}}, i_in_data.pen_x[31:6]}
                + {{20{i_in_data.glyph_left[7]}}, i_in_data.glyph_left}
                + {20'd0, i_in_data.pixel_column};
    assign n1_y = {{2{i_in_data.pen_y[31]}}, i_in_data.pen_y[31:6]}
                + {{20{i_in_data.glyph_top[7]}}, i_in_data.glyph_top}
                + {20'd0, i_in_data.pixel_row};

    // stage 2: clip, line offset product, in-line byte offset
    assign n2_pass = !r1_x[27] && (r1_x[26:0] < {11'd0, r_surface_width})
                  && !r1_y[27] && (r1_y[26:0] < {11'd0, r_surface_height})
                  && (r1_ink != 8'd0);
    assign n2_prod = 32'(r1_y[15:0]) * 32'(r_line_pitch);

    always_comb begin
        unique case (r_pixel_format)
            gimb_pkg::FMT_NIB_LO,
            gimb_pkg::FMT_NIB_HI: n2_off = 18'(r1_x[15:1]);
            gimb_pkg::FMT_BYTE:   n2_off = 18'(r1_x[15:0]);
            gimb_pkg::FMT_RGB:    n2_off = 18'(r1_x[15:0]) + 18'({r1_x[15:0], 1'b0});
            default:              n2_off = {r1_x[15:0], 2'b00};
        endcase
    end

    // stage 3: byte address, modulo the store size
    assign n3_at   = ADDR_W'(32'(r_surface_base) + r2_prod + 32'(r2_off));
    assign n3_high = (r_pixel_format == gimb_pkg::FMT_NIB_LO) ? r2_xodd : !r2_xodd;

    // 32-bit pixels read the ink byte, three above the first byte
    assign rd_byte = r3_at + ((r_pixel_format >= gimb_pkg::FMT_ARGB) ? ADDR_W'(3) : '0);
    assign rd_bank = rd_byte[1:0];
    assign rd_row  = rd_byte[ADDR_W-1:2];
    assign fwd_hit = s4_we[rd_bank] && (s4_wrow[rd_bank] == rd_row);

    // stage 4: merge with the old contents
    assign r4_row   = r4_at[ADDR_W-1:2];
    assign old_byte = r4_fwd_hit ? r4_fwd_byte : bank_rdata[r4_bank];
    assign max_byte = (old_byte > r4_ink) ? old_byte : r4_ink;
    assign old_nib  = r4_high ? old_byte[7:4] : old_byte[3:0];
    assign new_nib  = (old_nib > r4_ink[7:4]) ? old_nib : r4_ink[7:4];
    assign nib_byte = r4_high ? {new_nib, old_byte[3:0]} : {old_byte[7:4], new_nib};

    always_comb begin
        res = '0;
        if (r4_pass) begin
            res.written      = 1'b1;
            res.byte_address = 16'(32'(r4_at));
            unique case (r_pixel_format)
                gimb_pkg::FMT_NIB_LO,
                gimb_pkg::FMT_NIB_HI: begin
                    res.write_data = {24'd0, nib_byte};
                    res.byte_count = 3'd1;
                end
                gimb_pkg::FMT_BYTE: begin
                    res.write_data = {24'd0, max_byte};
                    res.byte_count = 3'd1;
                end
                gimb_pkg::FMT_RGB: begin
                    res.write_data = {8'd0, max_byte, max_byte, max_byte};
                    res.byte_count = 3'd3;
                end
                default: begin
                    res.write_data = {max_byte, 24'hFF_FFFF};
                    res.byte_count = 3'd4;
                end
            endcase
        end
    end

    // spread the written bytes over the four lanes, wrapping to the next row
    always_comb begin
        logic [1:0] k;
        k = '0;
        for (int l = 0; l < 4; l++) begin
            k           = 2'(l) - r4_at[1:0];
            s4_we[l]    = s4_move && (3'(k) < res.byte_count);
            s4_wrow[l]  = r4_row + ((2'(l) < r4_at[1:0]) ? ROW_W'(1) : '0);
            s4_wbyte[l] = res.write_data[8*k +: 8];
        end
    end

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            bank_we[l]    = r_clr_busy || s4_we[l];
            bank_wrow[l]  = r_clr_busy ? r_clr_row : s4_wrow[l];
            bank_wbyte[l] = r_clr_busy ? 8'd0 : s4_wbyte[l];
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_bank
        gimb_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (bank_we[g]),
            .i_waddr (bank_wrow[g]),
            .i_wdata (bank_wbyte[g]),
            .i_re    (s4_free),
            .i_raddr (rd_row),
            .o_rdata (bank_rdata[g])
        );
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format   <= gimb_pkg::RST_PIXEL_FORMAT;
            r_surface_width  <= gimb_pkg::RST_SURFACE_WIDTH;
            r_surface_height <= gimb_pkg::RST_SURFACE_HEIGHT;
            r_line_pitch     <= gimb_pkg::RST_LINE_PITCH;
            r_surface_base   <= gimb_pkg::RST_SURFACE_BASE;
            r_clr_busy       <= 1'b1;
            r_clr_row        <= '0;
            r1_valid         <= 1'b0;
            r2_valid         <= 1'b0;
            r3_valid         <= 1'b0;
            r4_valid         <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    gimb_pkg::CFG_PIXEL_FORMAT:   r_pixel_format   <= i_cfg_data[2:0];
                    gimb_pkg::CFG_SURFACE_WIDTH:  r_surface_width  <= i_cfg_data;
                    gimb_pkg::CFG_SURFACE_HEIGHT: r_surface_height <= i_cfg_data;
                    gimb_pkg::CFG_LINE_PITCH:     r_line_pitch     <= i_cfg_data;
                    gimb_pkg::CFG_SURFACE_BASE:   r_surface_base   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_clr_busy) begin
                r_clr_row <= r_clr_row + ROW_W'(1);
                if (&r_clr_row) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (s1_free) begin
                r1_valid <= in_xfer;
            end
            if (s2_free) begin
                r2_valid <= r1_valid;
            end
            if (s3_free) begin
                r3_valid <= r2_valid;
            end
            if (s4_free) begin
                r4_valid <= r3_valid;
            end
            if (out_free) begin
                r_out_valid <= r4_valid;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r1_x   <= n1_x;
            r1_y   <= n1_y;
            r1_ink <= i_in_data.ink;
        end
        if (s2_free) begin
            r2_pass <= n2_pass;
            r2_prod <= n2_prod;
            r2_off  <= n2_off;
            r2_xodd <= r1_x[0];
            r2_ink  <= r1_ink;
        end
        if (s3_free) begin
            r3_at   <= n3_at;
            r3_high <= n3_high;
            r3_pass <= r2_pass;
            r3_ink  <= r2_ink;
        end
        if (s4_free) begin
            r4_at       <= r3_at;
            r4_high     <= r3_high;
            r4_pass     <= r3_pass;
            r4_ink      <= r3_ink;
            r4_bank     <= rd_bank;
            r4_fwd_hit  <= fwd_hit;
            r4_fwd_byte <= s4_wbyte[rd_bank];
        end
        if (out_free) begin
            r_out_data <= res;
        end
    end

endmodule

[design/gimb_checker.sv]
// port-level checks on the glyph blit results, bound to the top level
`include "glyph_ink_max_blit_top_assert.svh"

module gimb_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input gimb_pkg::t_blit_out o_out_data
);

    // a stalled result stays put
    `GIMB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result changed while stalled")

    // a dropped pixel reports nothing
    `GIMB_ASSERT_NOW(a_skip_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.written, o_out_data.byte_count == 3'd0 && o_out_data.byte_address == 16'd0 && o_out_data.write_data == 32'd0, "skipped pixel with nonzero fields")

    // a write covers one, three or four bytes
    `GIMB_ASSERT_NOW(a_write_count, i_clk, i_rst_n, o_out_valid && o_out_data.written, o_out_data.byte_count == 3'd1 || o_out_data.byte_count == 3'd3 || o_out_data.byte_count == 3'd4, "bad byte count")

    // 24-bit pixels repeat one byte three times
    `GIMB_ASSERT_NOW(a_rgb_data, i_clk, i_rst_n, o_out_valid && o_out_data.byte_count == 3'd3, o_out_data.write_data[31:24] == 8'd0 && o_out_data.write_data[23:16] == o_out_data.write_data[7:0] && o_out_data.write_data[15:8] == o_out_data.write_data[7:0], "24-bit data not replicated")

    // 32-bit pixels sit over white
    `GIMB_ASSERT_NOW(a_argb_data, i_clk, i_rst_n, o_out_valid && o_out_data.byte_count == 3'd4, o_out_data.write_data[23:0] == 24'hFF_FFFF, "32-bit data not over white")

endmodule

bind glyph_ink_max_blit_top gimb_checker u_gimb_checker (.*);
